// ----- rtl/pts_pkg.sv -----
// Shared constants, types and command encodings of the priority task scheduler.
package pts_pkg;

  localparam int TASK_SLOTS = 31;
  localparam int TICK_BITS  = 32;

  localparam int MASK_W   = 31;
  localparam int DELAY_W  = 32;
  localparam int NEXT_W   = 5;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  localparam int PRIO_W = $clog2(TASK_SLOTS + 1);
  localparam int IDX_W  = $clog2(TASK_SLOTS + 1);
  localparam int ADDR_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef logic [TASK_SLOTS-1:0] slot_mask_t;
  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [PRIO_W-1:0]     prio_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [NEXT_W-1:0]     next_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_DELAY = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_IDLE_DELAY = 2'd1,
    ST_ZERO_DELAY = 2'd2
  } status_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic  load;
    logic  rd_en;
    addr_t rd_addr;
    logic  proc_en;
    addr_t proc_addr;
    logic  finish;
  } pts_cmd_t;

endpackage

// ----- rtl/pts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pts_ctrl.sv -----
// Sequencer of the scheduler: accepts a beat, walks the task slots, strobes the result.
module pts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output pts_pkg::pts_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e        state_q, state_d;
  pts_pkg::idx_t idx_q, idx_d;
  logic          walk;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (start_i) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        idx_d = idx_q + pts_pkg::idx_t'(1);
        if (idx_q == pts_pkg::idx_t'(pts_pkg::TASK_SLOTS)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign walk   = (state_q == S_WALK);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // The read for slot k is issued in the cycle before slot k is processed.
  assign cmd_o.load      = (state_q == S_IDLE) && start_i;
  assign cmd_o.rd_en     = walk && (idx_q < pts_pkg::idx_t'(pts_pkg::TASK_SLOTS));
  assign cmd_o.rd_addr   = pts_pkg::addr_t'(idx_q);
  assign cmd_o.proc_en   = walk && (idx_q != '0);
  assign cmd_o.proc_addr = pts_pkg::addr_t'(idx_q - pts_pkg::idx_t'(1));
  assign cmd_o.finish    = done_o;

endmodule

// ----- rtl/pts_dp.sv -----
// Datapath of the scheduler: task masks, timeout store and highest-priority pick.
module pts_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pts_pkg::pts_cmd_t            cmd_i,
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::MASK_W-1:0]   cfg_wdata_i,
  input  logic [pts_pkg::ACTION_W-1:0] action_i,
  input  logic [pts_pkg::DELAY_W-1:0]  delay_ticks_i,
  output logic [pts_pkg::NEXT_W-1:0]   next_task_o,
  output logic                         switch_needed_o,
  output logic [pts_pkg::STATUS_W-1:0] status_o
);

  logic [pts_pkg::MASK_W-1:0] present_q;
  pts_pkg::slot_mask_t        ready_q, delayed_q;
  pts_pkg::prio_t             cur_q, best_q;
  logic                       cur_valid_q;
  pts_pkg::action_e           action_q;
  pts_pkg::status_e           status_q;

  pts_pkg::slot_mask_t present_slots;
  pts_pkg::prio_t      cur_eff;
  pts_pkg::addr_t      cur_addr;
  pts_pkg::tick_t      ticks;
  pts_pkg::status_e    delay_status;
  logic                delay_ok;

  pts_pkg::tick_t ram_rdata, tick_dec;
  logic           tick_hit, expire, pick;

  logic           ram_we;
  pts_pkg::addr_t ram_waddr;
  pts_pkg::tick_t ram_wdata;

  assign present_slots = pts_pkg::slot_mask_t'(present_q);
  assign cur_eff       = cur_valid_q ? cur_q : '0;
  assign cur_addr      = pts_pkg::addr_t'(cur_eff - pts_pkg::prio_t'(1));
  assign ticks         = pts_pkg::tick_t'(delay_ticks_i);

  // The idle check takes precedence over the zero-tick check.
  always_comb begin
    if (cur_eff == '0) begin
      delay_status = pts_pkg::ST_IDLE_DELAY;
    end else if (ticks == '0) begin
      delay_status = pts_pkg::ST_ZERO_DELAY;
    end else begin
      delay_status = pts_pkg::ST_OK;
    end
  end

  assign delay_ok = (action_i == pts_pkg::ACT_DELAY) && (delay_status == pts_pkg::ST_OK);

  // Per-slot work during the walk: count down a delayed timeout and test readiness.
  assign tick_dec = ram_rdata - pts_pkg::tick_t'(1);
  assign tick_hit = (action_q == pts_pkg::ACT_TICK) && delayed_q[cmd_i.proc_addr];
  assign expire   = tick_hit && (tick_dec == '0);
  assign pick     = (ready_q[cmd_i.proc_addr] || expire) && present_slots[cmd_i.proc_addr];

  assign ram_we    = (cmd_i.load && delay_ok) || (cmd_i.proc_en && tick_hit);
  assign ram_waddr = cmd_i.load ? cur_addr : cmd_i.proc_addr;
  assign ram_wdata = cmd_i.load ? ticks : tick_dec;

  pts_ram #(
    .WIDTH(pts_pkg::TICK_BITS),
    .DEPTH(pts_pkg::TASK_SLOTS)
  ) u_ticks_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      ready_q     <= '0;
      delayed_q   <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        case (pts_pkg::action_e'(action_i))
          pts_pkg::ACT_START: begin
            ready_q   <= present_slots;
            delayed_q <= '0;
          end
          pts_pkg::ACT_DELAY: begin
            if (delay_ok) begin
              ready_q[cur_addr]   <= 1'b0;
              delayed_q[cur_addr] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.proc_en && expire) begin
        ready_q[cmd_i.proc_addr]   <= 1'b1;
        delayed_q[cmd_i.proc_addr] <= 1'b0;
      end
      if (cmd_i.finish) begin
        cur_q       <= best_q;
        cur_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= pts_pkg::action_e'(action_i);
      status_q <= (action_i == pts_pkg::ACT_DELAY) ? delay_status : pts_pkg::ST_OK;
      best_q   <= '0;
    end else if (cmd_i.proc_en && pick) begin
      // Slots are walked upwards, so the last hit is the highest priority.
      best_q <= pts_pkg::prio_t'(cmd_i.proc_addr) + pts_pkg::prio_t'(1);
    end
  end

  assign next_task_o     = pts_pkg::next_t'(best_q);
  assign switch_needed_o = !cur_valid_q || (best_q != cur_q);
  assign status_o        = status_q;

endmodule

// ----- rtl/priority_task_scheduler_core.sv -----
// Top level of the priority task scheduler: sequencer, datapath and checks.
//
//   Channel   Direction  Beat marked by          Payload
//   command   in         start_i && !busy_o      action_i, delay_ticks_i
//   result    out        done_o (one cycle)      next_task_o, switch_needed_o, status_o
//   config    in         cfg_we_i                cfg_wdata_i (task present mask)
//
// Every command beat passes through acceptance in the idle state, a walk over the timeout
// RAM, one slot per cycle behind its registered read, and the result state; no new beat is
// accepted before the result state has passed.
// Reset is asynchronous and active low; it clears the masks and the current task.
// The receiver cannot stall: the result is shown for exactly one cycle.
module priority_task_scheduler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pts_pkg::MASK_W-1:0]   cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [pts_pkg::ACTION_W-1:0] action_i,
  input  logic [pts_pkg::DELAY_W-1:0]  delay_ticks_i,
  output logic                         done_o,
  output logic [pts_pkg::NEXT_W-1:0]   next_task_o,
  output logic                         switch_needed_o,
  output logic [pts_pkg::STATUS_W-1:0] status_o
);

  pts_pkg::pts_cmd_t cmd;

  // The sequencer owns the slot counter and issues the RAM reads one slot ahead of
  // the slot that the datapath is processing.
  pts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // The datapath applies start and delay at acceptance, then counts down the delayed
  // timeouts and picks the highest ready, present priority during the walk.
  pts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .delay_ticks_i  (delay_ticks_i),
    .next_task_o    (next_task_o),
    .switch_needed_o(switch_needed_o),
    .status_o       (status_o)
  );

  // An accepted beat keeps the block busy in the following cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after an accepted beat");

  // The block is free again right after the result strobe.
  a_done_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after the result strobe");

  // A result only follows a busy cycle.
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a beat in flight");

  // The status reported with a result is always one of the defined codes.
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == pts_pkg::ST_OK || status_o == pts_pkg::ST_IDLE_DELAY ||
                status_o == pts_pkg::ST_ZERO_DELAY))
    else $error("undefined status code on the result");

endmodule
